/* rtl/core/hsvrgb_pkg.sv */
// shared types, widths and constants for the hsv to rgb converter
package hsvrgb_pkg;

	// field widths
	localparam int unsigned HUE_W = 9;
	localparam int unsigned PCT_W = 7;
	localparam int unsigned CH_W  = 8;

	// internal widths (values are exact counts of 1/600000)
	localparam int unsigned FRAC_W = 6;   // secondary weight 0..60
	localparam int unsigned SV_W   = 14;  // percent products 0..10000
	localparam int unsigned CMP_W  = 20;  // components 0..600000
	localparam int unsigned PRE_W  = 24;  // component * 17, 0..10200000
	localparam int unsigned Z_W    = 18;  // prescaled value 0..159375
	localparam int unsigned PROD_W = 37;  // prescaled value * reciprocal

	// colour model constants
	localparam int unsigned HUE_TURN   = 360;
	localparam int unsigned PCT_FULL   = 100;
	localparam int unsigned SECTOR_DEG = 60;

	// 255 / 600000 = 17 / (64 * 625)
	localparam int unsigned PRE_MUL   = 17;
	localparam int unsigned PRE_SHIFT = 6;
	// ceil(2^28 / 625), exact for every prescaled value below 2^18
	localparam int unsigned RECIP       = 429497;
	localparam int unsigned RECIP_SHIFT = 28;

	// channel slots
	localparam int unsigned CH_RED   = 0;
	localparam int unsigned CH_GREEN = 1;
	localparam int unsigned CH_BLUE  = 2;

	// 60 degree hue sectors
	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYA = 3'd2,
		SEC_CYA_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [PCT_W-1:0] saturation;
		logic [PCT_W-1:0] brightness;
	} hsv_word_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_word_t;

	typedef logic [Z_W-1:0] scaled_t;

endpackage

/* rtl/core/hsvrgb_prep.sv */
// stages 1 and 2: input wrap and clamp, hue sector, percent products
module hsvrgb_prep import hsvrgb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                feed_valid,
	output logic                feed_load,
	input  hsv_word_t           feed,
	output logic                pass_valid,
	input  logic                pass_load,
	output sector_t             sec,
	output logic [FRAC_W-1:0]   frac,
	output logic [SV_W-1:0]     sv,
	output logic [SV_W-1:0]     vn
);

	logic                en_s1, en_s2;
	logic                vld_s1, vld_s2;
	logic [HUE_W-1:0]    hue_s1;
	logic [PCT_W-1:0]    sat_s1, bri_s1;
	logic [HUE_W-1:0]    hue_d;
	logic [PCT_W-1:0]    sat_d, bri_d;
	sector_t             sec_d, sec_s2;
	logic [HUE_W-1:0]    base_d, diff_d;
	logic [FRAC_W-1:0]   rem_d, frac_d, frac_s2;
	logic [SV_W-1:0]     sv_d, vn_d, sv_s2, vn_s2;

	// stage enables, a bubble is always overwritten
	assign en_s2     = !vld_s2 || pass_load;
	assign en_s1     = !vld_s1 || en_s2;
	assign feed_load = en_s1;

	// wrap hue once, clamp percentages
	always_comb begin
		hue_d = (feed.hue >= HUE_W'(HUE_TURN)) ? feed.hue - HUE_W'(HUE_TURN) : feed.hue;
		sat_d = (feed.saturation > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : feed.saturation;
		bri_d = (feed.brightness > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : feed.brightness;
	end

	// sector and position within it
	always_comb begin
		if (hue_s1 < HUE_W'(SECTOR_DEG)) begin
			sec_d  = SEC_RED_YEL;
			base_d = '0;
		end else if (hue_s1 < HUE_W'(2 * SECTOR_DEG)) begin
			sec_d  = SEC_YEL_GRN;
			base_d = HUE_W'(SECTOR_DEG);
		end else if (hue_s1 < HUE_W'(3 * SECTOR_DEG)) begin
			sec_d  = SEC_GRN_CYA;
			base_d = HUE_W'(2 * SECTOR_DEG);
		end else if (hue_s1 < HUE_W'(4 * SECTOR_DEG)) begin
			sec_d  = SEC_CYA_BLU;
			base_d = HUE_W'(3 * SECTOR_DEG);
		end else if (hue_s1 < HUE_W'(5 * SECTOR_DEG)) begin
			sec_d  = SEC_BLU_MAG;
			base_d = HUE_W'(4 * SECTOR_DEG);
		end else begin
			sec_d  = SEC_MAG_RED;
			base_d = HUE_W'(5 * SECTOR_DEG);
		end
		diff_d = hue_s1 - base_d;
		rem_d  = diff_d[FRAC_W-1:0];
		// rising edge of the secondary in even sectors, falling in odd ones
		frac_d = sec_d[0] ? FRAC_W'(SECTOR_DEG) - rem_d : rem_d;
	end

	// s*v for chroma, v*(100-s) for the offset
	always_comb begin
		sv_d = SV_W'(sat_s1) * SV_W'(bri_s1);
		vn_d = SV_W'(bri_s1) * SV_W'(PCT_W'(PCT_FULL) - sat_s1);
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= feed_valid;
			if (en_s2) vld_s2 <= vld_s1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en_s1 && feed_valid) begin
			hue_s1 <= hue_d;
			sat_s1 <= sat_d;
			bri_s1 <= bri_d;
		end
		if (en_s2 && vld_s1) begin
			sec_s2  <= sec_d;
			frac_s2 <= frac_d;
			sv_s2   <= sv_d;
			vn_s2   <= vn_d;
		end
	end

	assign pass_valid = vld_s2;
	assign sec        = sec_s2;
	assign frac       = frac_s2;
	assign sv         = sv_s2;
	assign vn         = vn_s2;

endmodule

/* rtl/core/hsvrgb_mix.sv */
// stages 3 and 4: chroma, secondary and offset, channel placement and prescale
module hsvrgb_mix import hsvrgb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                feed_valid,
	output logic                feed_load,
	input  sector_t             sec,
	input  logic [FRAC_W-1:0]   frac,
	input  logic [SV_W-1:0]     sv,
	input  logic [SV_W-1:0]     vn,
	output logic                pass_valid,
	input  logic                pass_load,
	output scaled_t [2:0]       scaled
);

	logic                en_s3, en_s4;
	logic                vld_s3, vld_s4;
	logic [CMP_W-1:0]    chroma_d, second_d, offs_d;
	logic [CMP_W-1:0]    chroma_s3, second_s3, offs_s3;
	sector_t             sec_s3;
	logic [CMP_W-1:0]    comp_d [3];
	logic [CMP_W-1:0]    sum_d  [3];
	logic [PRE_W-1:0]    pre_d  [3];
	scaled_t [2:0]       scaled_d, scaled_s4;

	assign en_s4     = !vld_s4 || pass_load;
	assign en_s3     = !vld_s3 || en_s4;
	assign feed_load = en_s3;

	// components in units of 1/600000
	always_comb begin
		chroma_d = CMP_W'(sv) * CMP_W'(SECTOR_DEG);
		second_d = CMP_W'(sv) * CMP_W'(frac);
		offs_d   = CMP_W'(vn) * CMP_W'(SECTOR_DEG);
	end

	// place chroma and secondary by sector
	always_comb begin
		comp_d[CH_RED]   = '0;
		comp_d[CH_GREEN] = '0;
		comp_d[CH_BLUE]  = '0;
		case (sec_s3)
			SEC_RED_YEL: begin
				comp_d[CH_RED]   = chroma_s3;
				comp_d[CH_GREEN] = second_s3;
			end
			SEC_YEL_GRN: begin
				comp_d[CH_RED]   = second_s3;
				comp_d[CH_GREEN] = chroma_s3;
			end
			SEC_GRN_CYA: begin
				comp_d[CH_GREEN] = chroma_s3;
				comp_d[CH_BLUE]  = second_s3;
			end
			SEC_CYA_BLU: begin
				comp_d[CH_GREEN] = second_s3;
				comp_d[CH_BLUE]  = chroma_s3;
			end
			SEC_BLU_MAG: begin
				comp_d[CH_RED]   = second_s3;
				comp_d[CH_BLUE]  = chroma_s3;
			end
			default: begin
				comp_d[CH_RED]   = chroma_s3;
				comp_d[CH_BLUE]  = second_s3;
			end
		endcase
	end

	// add offset, multiply by 17 and drop six bits (first part of *255/600000)
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum_d[i]    = comp_d[i] + offs_s3;
			pre_d[i]    = PRE_W'(sum_d[i]) * PRE_W'(PRE_MUL);
			scaled_d[i] = pre_d[i][PRE_SHIFT +: Z_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en_s3) vld_s3 <= feed_valid;
			if (en_s4) vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && feed_valid) begin
			chroma_s3 <= chroma_d;
			second_s3 <= second_d;
			offs_s3   <= offs_d;
			sec_s3    <= sec;
		end
		if (en_s4 && vld_s3) begin
			scaled_s4 <= scaled_d;
		end
	end

	assign pass_valid = vld_s4;
	assign scaled     = scaled_s4;

endmodule

/* rtl/core/hsvrgb_scale.sv */
// stage 5: divide by 625 through the reciprocal, output register
module hsvrgb_scale import hsvrgb_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            feed_valid,
	output logic            feed_load,
	input  scaled_t [2:0]   scaled,
	output logic            rgb_valid,
	input  logic            rgb_stall,
	output rgb_word_t       rgb
);

	logic                en_s5;
	logic                vld_s5;
	logic [PROD_W-1:0]   prod_d [3];
	logic [CH_W-1:0]     chan_d [3];
	rgb_word_t           rgb_s5;

	assign en_s5     = !vld_s5 || !rgb_stall;
	assign feed_load = en_s5;

	// floor(z / 625) as (z * ceil(2^28/625)) >> 28
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod_d[i] = PROD_W'(scaled[i]) * PROD_W'(RECIP);
			chan_d[i] = prod_d[i][RECIP_SHIFT +: CH_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en_s5) begin
			vld_s5 <= feed_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5 && feed_valid) begin
			rgb_s5.red   <= chan_d[CH_RED];
			rgb_s5.green <= chan_d[CH_GREEN];
			rgb_s5.blue  <= chan_d[CH_BLUE];
		end
	end

	assign rgb_valid = vld_s5;
	assign rgb       = rgb_s5;

endmodule

/* rtl/core/hsv_to_rgb_converter_unit.sv */
// hsv to rgb pixel converter, five register stages
// a taken word moves through stages 1 to 5 in order; rgb_valid comes from the stage 5 register
// throughput: one word per cycle unless stalled; stages advance alone, so bubbles close up
// hsv_stall rises only when all five stages hold words and rgb is stalled
// reset (arst_n low) clears every valid bit at once; data registers are not reset
module hsv_to_rgb_converter_unit import hsvrgb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        hsv_valid,
	output logic        hsv_stall,
	input  hsv_word_t   hsv,
	output logic        rgb_valid,
	input  logic        rgb_stall,
	output rgb_word_t   rgb
);

	logic                load_a, load_b, load_c;
	logic                vld_ab, vld_bc;
	sector_t             sec_ab;
	logic [FRAC_W-1:0]   frac_ab;
	logic [SV_W-1:0]     sv_ab, vn_ab;
	scaled_t [2:0]       scaled_bc;
	logic [2:0]          inflight_q;
	logic                take_in, take_out;

	assign hsv_stall = !load_a;

	// stages 1-2
	hsvrgb_prep u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.feed_valid (hsv_valid),
		.feed_load  (load_a),
		.feed       (hsv),
		.pass_valid (vld_ab),
		.pass_load  (load_b),
		.sec        (sec_ab),
		.frac       (frac_ab),
		.sv         (sv_ab),
		.vn         (vn_ab)
	);

	// stages 3-4
	hsvrgb_mix u_mix (
		.clk        (clk),
		.arst_n     (arst_n),
		.feed_valid (vld_ab),
		.feed_load  (load_b),
		.sec        (sec_ab),
		.frac       (frac_ab),
		.sv         (sv_ab),
		.vn         (vn_ab),
		.pass_valid (vld_bc),
		.pass_load  (load_c),
		.scaled     (scaled_bc)
	);

	// stage 5
	hsvrgb_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.feed_valid (vld_bc),
		.feed_load  (load_c),
		.scaled     (scaled_bc),
		.rgb_valid  (rgb_valid),
		.rgb_stall  (rgb_stall),
		.rgb        (rgb)
	);

	// words in flight, for the checks below
	assign take_in  = hsv_valid && !hsv_stall;
	assign take_out = rgb_valid && !rgb_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (take_in && !take_out) begin
			inflight_q <= inflight_q + 3'd1;
		end else if (take_out && !take_in) begin
			inflight_q <= inflight_q - 3'd1;
		end
	end

	// input only backs up when the output word is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_stall |-> (rgb_valid && rgb_stall))
		else $error("input stalled while output free");

	// never more words held than stages
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd5)
		else $error("pipeline holds more than five words");

	// no output word without a matching input word
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid |-> (inflight_q != 3'd0))
		else $error("output word with nothing in flight");

endmodule

/* tb/tb_hsv_to_rgb_converter_unit.sv */
// testbench for the hsv to rgb converter: predicted rgb words checked against the block
`timescale 1ns / 100ps
module tb_hsv_to_rgb_converter_unit import hsvrgb_pkg::*; ();

	localparam int unsigned CH_MAX       = (1 << CH_W) - 1;
	localparam int unsigned FIX_SCALE    = PCT_FULL * PCT_FULL * SECTOR_DEG;
	localparam int unsigned HOLD_CYCLES  = 60;
	localparam int unsigned IDLE_LIMIT   = 2000;
	localparam int unsigned TAIL_CYCLES  = 20;
	localparam int unsigned FLOOD_WORDS  = 40;
	localparam int unsigned FIRST_WORDS  = 500;
	localparam int unsigned RANDOM_WORDS = 1030;

	typedef enum int unsigned {
		STALL_NONE,
		STALL_HALF,
		STALL_LIGHT,
		STALL_PERIODIC
	} stall_mode_t;

	// expected rgb words and the colour conversion that produces them
	class rgb_scoreboard;
		rgb_word_t   expected_rgb[$];
		int unsigned mismatch_count;

		function int unsigned channel_level(int unsigned comp, int unsigned offs);
			int unsigned level;
			level = ((comp + offs) * CH_MAX) / FIX_SCALE;
			return (level > CH_MAX) ? CH_MAX : level;
		endfunction

		// exact fixed point, every quantity in units of 1/600000
		function rgb_word_t hsv_to_rgb(hsv_word_t w);
			int unsigned h, s, v, hm, hdist, chroma, second, offs;
			int unsigned r, g, b;
			sector_t     sector;
			rgb_word_t   res;
			h = w.hue % HUE_TURN;
			s = (w.saturation > PCT_FULL) ? PCT_FULL : w.saturation;
			v = (w.brightness > PCT_FULL) ? PCT_FULL : w.brightness;
			hm = h % (2 * SECTOR_DEG);
			hdist = (hm >= SECTOR_DEG) ? (hm - SECTOR_DEG) : (SECTOR_DEG - hm);
			chroma = s * v * SECTOR_DEG;
			second = s * v * (SECTOR_DEG - hdist);
			offs = SECTOR_DEG * v * (PCT_FULL - s);
			sector = sector_t'(h / SECTOR_DEG);
			case (sector)
				SEC_RED_YEL: begin
					r = chroma; g = second; b = 0;
				end
				SEC_YEL_GRN: begin
					r = second; g = chroma; b = 0;
				end
				SEC_GRN_CYA: begin
					r = 0; g = chroma; b = second;
				end
				SEC_CYA_BLU: begin
					r = 0; g = second; b = chroma;
				end
				SEC_BLU_MAG: begin
					r = second; g = 0; b = chroma;
				end
				default: begin
					r = chroma; g = 0; b = second;
				end
			endcase
			res.red   = CH_W'(channel_level(r, offs));
			res.green = CH_W'(channel_level(g, offs));
			res.blue  = CH_W'(channel_level(b, offs));
			return res;
		endfunction

		function void note_pixel(hsv_word_t w);
			expected_rgb.push_back(hsv_to_rgb(w));
		endfunction

		function void check_pixel(rgb_word_t got);
			rgb_word_t want;
			if (expected_rgb.size() == 0) begin
				$error("rgb word %h arrived with nothing expected", got);
				mismatch_count++;
				return;
			end
			want = expected_rgb.pop_front();
			if (got.red !== want.red) begin
				$error("red: expected %0d, actual %0d", want.red, got.red);
				mismatch_count++;
			end
			if (got.green !== want.green) begin
				$error("green: expected %0d, actual %0d", want.green, got.green);
				mismatch_count++;
			end
			if (got.blue !== want.blue) begin
				$error("blue: expected %0d, actual %0d", want.blue, got.blue);
				mismatch_count++;
			end
		endfunction

		function int unsigned pending();
			return expected_rgb.size();
		endfunction
	endclass

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      hsv_valid = 1'b0;
	logic      hsv_stall;
	hsv_word_t hsv       = '0;
	logic      rgb_valid;
	logic      rgb_stall = 1'b0;
	rgb_word_t rgb;

	rgb_scoreboard board = new();
	int unsigned   burst_left;
	int unsigned   quiet_cycles;
	bit            long_hold_req;

	wire hsv_taken = arst_n && hsv_valid && !hsv_stall;
	wire rgb_taken = arst_n && rgb_valid && !rgb_stall;

	hsv_to_rgb_converter_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.hsv_valid (hsv_valid),
		.hsv_stall (hsv_stall),
		.hsv       (hsv),
		.rgb_valid (rgb_valid),
		.rgb_stall (rgb_stall),
		.rgb       (rgb)
	);

	always #5 clk = ~clk;

	// note accepted hsv words, check accepted rgb words
	always @(posedge clk) begin
		if (hsv_taken) begin
			board.note_pixel(hsv);
		end
		if (rgb_taken) begin
			board.check_pixel(rgb);
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (hsv_taken || rgb_taken || !arst_n) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// receiver stall pattern, with a long hold on request
	initial begin : receiver
		int unsigned seg_len, k;
		stall_mode_t mode;
		forever begin
			if (long_hold_req) begin
				rgb_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold_req = 1'b0;
			end else begin
				seg_len = $urandom_range(4, 60);
				mode = stall_mode_t'($urandom_range(STALL_NONE, STALL_PERIODIC));
				for (k = 0; k < seg_len && !long_hold_req; k++) begin
					case (mode)
						STALL_NONE:     rgb_stall <= 1'b0;
						STALL_HALF:     rgb_stall <= ($urandom_range(0, 1) == 1);
						STALL_LIGHT:    rgb_stall <= ($urandom_range(0, 3) == 0);
						default:        rgb_stall <= (k % 3 == 2);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	function automatic hsv_word_t pix(int unsigned h, int unsigned s, int unsigned v);
		hsv_word_t w;
		w.hue        = HUE_W'(h);
		w.saturation = PCT_W'(s);
		w.brightness = PCT_W'(v);
		return w;
	endfunction

	// mostly in-range pixels, some sector edges and some raw out-of-range codes
	function automatic hsv_word_t random_pixel();
		hsv_word_t w;
		case ($urandom_range(0, 9))
			0: begin
				w.hue        = HUE_W'($urandom_range(0, (1 << HUE_W) - 1));
				w.saturation = PCT_W'($urandom_range(0, (1 << PCT_W) - 1));
				w.brightness = PCT_W'($urandom_range(0, (1 << PCT_W) - 1));
			end
			1: begin
				w.hue = HUE_W'($urandom_range(0, 5) * SECTOR_DEG
					+ ($urandom_range(0, 1) ? SECTOR_DEG - 1 : 0));
				w.saturation = PCT_W'($urandom_range(0, 1) ? PCT_FULL : 0);
				w.brightness = PCT_W'($urandom_range(0, 1) ? PCT_FULL : 0);
			end
			default: begin
				w.hue        = HUE_W'($urandom_range(0, HUE_TURN - 1));
				w.saturation = PCT_W'($urandom_range(0, PCT_FULL));
				w.brightness = PCT_W'($urandom_range(0, PCT_FULL));
			end
		endcase
		return w;
	endfunction

	// hold the word until the block takes it
	task automatic send_pixel(input hsv_word_t w);
		hsv       <= w;
		hsv_valid <= 1'b1;
		@(posedge clk);
		while (hsv_stall) @(posedge clk);
	endtask

	task automatic idle_gap(input int unsigned n);
		hsv_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// bursts of random length with random gaps between them
	task automatic offer_pixel(input hsv_word_t w);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 8);
			if (gap != 0) begin
				idle_gap(gap);
			end
			burst_left = $urandom_range(1, 48);
		end
		send_pixel(w);
		burst_left--;
	endtask

	task automatic wait_drained();
		hsv_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		int unsigned k;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		burst_left = 0;

		// both edges of every sector at full colour
		for (k = 0; k < 6; k++) begin
			offer_pixel(pix(k * SECTOR_DEG, PCT_FULL, PCT_FULL));
			offer_pixel(pix(k * SECTOR_DEG + SECTOR_DEG - 1, PCT_FULL, PCT_FULL));
		end
		// grey, black and a mid tone
		offer_pixel(pix(200, 0, PCT_FULL));
		offer_pixel(pix(100, PCT_FULL, 0));
		offer_pixel(pix(0, 0, 0));
		offer_pixel(pix(30, 50, 50));
		// hue wrap past a full turn
		offer_pixel(pix(HUE_TURN, PCT_FULL, PCT_FULL));
		offer_pixel(pix(420, 70, 90));
		offer_pixel(pix((1 << HUE_W) - 1, PCT_FULL, PCT_FULL));
		// saturation and brightness clipped at full scale
		offer_pixel(pix(150, PCT_FULL + 1, 80));
		offer_pixel(pix(250, (1 << PCT_W) - 1, 60));
		offer_pixel(pix(320, 40, PCT_FULL + 1));
		offer_pixel(pix((1 << HUE_W) - 1, (1 << PCT_W) - 1, (1 << PCT_W) - 1));

		// sender pauses until every rgb word is back
		wait_drained();

		// receiver holds off while the sender floods the pipeline
		long_hold_req = 1'b1;
		for (k = 0; k < FLOOD_WORDS; k++) begin
			send_pixel(random_pixel());
		end
		for (k = 0; k < FIRST_WORDS; k++) begin
			offer_pixel(random_pixel());
		end
		wait_drained();
		for (k = FLOOD_WORDS + FIRST_WORDS; k < RANDOM_WORDS; k++) begin
			offer_pixel(random_pixel());
		end

		// drain, then watch for stray words
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.mismatch_count == 0 && board.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/hsvrgb_pkg.sv
rtl/core/hsvrgb_prep.sv
rtl/core/hsvrgb_mix.sv
rtl/core/hsvrgb_scale.sv
rtl/core/hsv_to_rgb_converter_unit.sv
tb/tb_hsv_to_rgb_converter_unit.sv
